// File: design/lpa_pkg.sv
package lpa_pkg;

   localparam int FRAC_BITS   = 16;
   localparam int COORD_BITS  = 16;
   localparam int REG_BITS    = 16;
   localparam int FRAME_BITS  = 31;
   localparam int ACC_BITS    = 48;
   localparam int DIFF_BITS   = REG_BITS + 1;
   localparam int MAG_BITS    = COORD_BITS + FRAC_BITS;
   localparam int CNT_BITS    = $clog2(MAG_BITS + 1);
   localparam int CSR_IDX_BITS  = 3;
   localparam int CSR_DATA_BITS = 32;

   localparam logic [CNT_BITS-1:0] DIV_COUNT = CNT_BITS'(MAG_BITS);
   localparam logic [ACC_BITS-1:0] ROUND_HALF = ACC_BITS'(1) << (FRAC_BITS - 1);

   localparam logic [CSR_IDX_BITS-1:0] CSR_START_X     = 3'd0;
   localparam logic [CSR_IDX_BITS-1:0] CSR_START_Y     = 3'd1;
   localparam logic [CSR_IDX_BITS-1:0] CSR_STOP_X      = 3'd2;
   localparam logic [CSR_IDX_BITS-1:0] CSR_STOP_Y      = 3'd3;
   localparam logic [CSR_IDX_BITS-1:0] CSR_BEGIN_FRAME = 3'd4;
   localparam logic [CSR_IDX_BITS-1:0] CSR_END_FRAME   = 3'd5;

   typedef struct packed {
      logic load_req;
      logic rearm;
      logic mul_start;
      logic mul_step;
      logic load_stop;
      logic load_round;
   } lpa_cmd_type;

   typedef struct packed {
      logic cfg_write;
      logic div_busy;
      logic past_end;
      logic later;
      logic elapsed_zero;
   } lpa_status_type;

   // sign-extend the low COORD_BITS of a coordinate register
   function automatic logic [REG_BITS-1:0] coord_ext(input logic [REG_BITS-1:0] r);
      logic [REG_BITS-1:0] v;
      for (int i = 0; i < REG_BITS; i++) begin
         v[i] = (i < COORD_BITS) ? r[i] : r[COORD_BITS-1];
      end
      return v;
   endfunction

endpackage

// File: design/fixed_point_line_path_animator.sv
// Line path animator: moves a point from (start_x, start_y) to (stop_x, stop_y) between
// begin_frame and end_frame, answering one request per frame query with the position rounded
// to the nearest integer. Requests are handled one at a time. A request past end_frame or
// not after the current frame answers with the stop position or the current position, and
// one that moves the point forward first multiplies the frames elapsed since the last query
// (up to 31 significant bits) by the step in the bit-serial shift-add multiplier; then the result waits in the
// output register until taken. The first request after reset or after a write to one of the six
// registers also runs the step division first: two restoring dividers side by side, skipped when
// end_frame is not after begin_frame. Register writes are taken in any cycle, but should be made
// only while no request is in flight.
module fixed_point_line_path_animator import lpa_pkg::*; (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_stall,
   input  logic [FRAME_BITS-1:0]    req_now_frame,
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output logic signed [REG_BITS-1:0] rsp_pos_x,
   output logic signed [REG_BITS-1:0] rsp_pos_y,
   input  logic                     csr_valid,
   output logic                     csr_ready,
   input  logic [CSR_IDX_BITS-1:0]  csr_index,
   input  logic [CSR_DATA_BITS-1:0] csr_wdata
);

   lpa_cmd_type    cmd;
   lpa_status_type status;
   logic [REG_BITS-1:0] pos_x, pos_y;

   assign csr_ready = 1'b1;

   lpa_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .status    (status),
      .cmd       (cmd)
   );

   lpa_datapath u_datapath (
      .clock         (clock),
      .reset         (reset),
      .cmd           (cmd),
      .status        (status),
      .csr_valid     (csr_valid),
      .csr_index     (csr_index),
      .csr_wdata     (csr_wdata),
      .req_now_frame (req_now_frame),
      .rsp_pos_x     (pos_x),
      .rsp_pos_y     (pos_y)
   );

   assign rsp_pos_x = $signed(pos_x);
   assign rsp_pos_y = $signed(pos_y);

   // one request in flight: no new request while a result is pending
   a_single_flight: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> req_stall)
      else $error("request accepted while a result is pending");

   a_stall_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> req_stall)
      else $error("input not stalled after a request was accepted");

   a_rearm_div_idle: assert property (@(posedge clock) disable iff (reset)
      cmd.rearm |-> !status.div_busy)
      else $error("rearm issued while the step dividers are busy");

   a_mul_not_during_div: assert property (@(posedge clock) disable iff (reset)
      (cmd.mul_start || cmd.mul_step) |-> !status.div_busy)
      else $error("position update while the step dividers are busy");

endmodule

// File: design/lpa_div.sv
module lpa_div import lpa_pkg::*; (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   input  logic signed [DIFF_BITS-1:0] diff,
   input  logic [FRAME_BITS-1:0]       span,
   output logic                        busy,
   output logic                        done,
   output logic [ACC_BITS-1:0]         quot
);

   logic                  busy_ff, busy_in;
   logic                  done_ff, done_in;
   logic                  neg_ff, neg_in;
   logic [CNT_BITS-1:0]   count_ff, count_in;
   logic [FRAME_BITS-1:0] rem_ff, rem_in;
   logic [MAG_BITS-1:0]   num_ff, num_in;

   logic signed [DIFF_BITS-1:0] neg_diff;
   logic [COORD_BITS-1:0]       mag;
   logic [FRAME_BITS:0]         trial;
   logic [FRAME_BITS:0]         trial_sub;
   logic                        fits;
   logic [ACC_BITS-1:0]         mag_ext;

   always_comb begin
      neg_diff  = -diff;
      mag       = diff[DIFF_BITS-1] ? neg_diff[COORD_BITS-1:0] : diff[COORD_BITS-1:0];
      trial     = {rem_ff, num_ff[MAG_BITS-1]};
      fits      = trial >= {1'b0, span};
      trial_sub = trial - {1'b0, span};

      busy_in  = busy_ff;
      done_in  = 1'b0;
      neg_in   = neg_ff;
      count_in = count_ff;
      rem_in   = rem_ff;
      num_in   = num_ff;

      if (start) begin
         busy_in  = 1'b1;
         count_in = DIV_COUNT;
         rem_in   = '0;
         num_in   = {mag, {FRAC_BITS{1'b0}}};
         neg_in   = diff[DIFF_BITS-1];
      end else if (busy_ff) begin
         // restoring step, quotient bits shift in behind the dividend bits
         rem_in   = fits ? trial_sub[FRAME_BITS-1:0] : trial[FRAME_BITS-1:0];
         num_in   = {num_ff[MAG_BITS-2:0], fits};
         count_in = count_ff - CNT_BITS'(1);
         if (count_ff == CNT_BITS'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      neg_ff   <= neg_in;
      count_ff <= count_in;
      rem_ff   <= rem_in;
      num_ff   <= num_in;
   end

   assign mag_ext = {{(ACC_BITS-MAG_BITS){1'b0}}, num_ff};
   assign quot    = neg_ff ? -mag_ext : mag_ext;
   assign busy    = busy_ff;
   assign done    = done_ff;

endmodule

// File: design/lpa_datapath.sv
module lpa_datapath import lpa_pkg::*; (
   input  logic                     clock,
   input  logic                     reset,
   input  lpa_cmd_type              cmd,
   output lpa_status_type           status,
   input  logic                     csr_valid,
   input  logic [CSR_IDX_BITS-1:0]  csr_index,
   input  logic [CSR_DATA_BITS-1:0] csr_wdata,
   input  logic [FRAME_BITS-1:0]    req_now_frame,
   output logic [REG_BITS-1:0]      rsp_pos_x,
   output logic [REG_BITS-1:0]      rsp_pos_y
);

   logic [REG_BITS-1:0]   start_x_ff, start_y_ff, stop_x_ff, stop_y_ff;
   logic [FRAME_BITS-1:0] begin_frame_ff, end_frame_ff;
   logic                  cfg_hit;

   logic [FRAME_BITS-1:0] now_ff, now_in;
   logic [FRAME_BITS-1:0] current_frame_ff, current_frame_in;
   logic [FRAME_BITS-1:0] elapsed_ff, elapsed_in;
   logic [ACC_BITS-1:0]   accum_x_ff, accum_x_in, accum_y_ff, accum_y_in;
   logic [ACC_BITS-1:0]   step_x_ff, step_x_in, step_y_ff, step_y_in;
   logic [ACC_BITS-1:0]   mcand_x_ff, mcand_x_in, mcand_y_ff, mcand_y_in;
   logic [REG_BITS-1:0]   pos_x_ff, pos_x_in, pos_y_ff, pos_y_in;

   logic [REG_BITS-1:0]         sx, sy, ex, ey;
   logic signed [DIFF_BITS-1:0] diff_x, diff_y;
   logic [FRAME_BITS-1:0]       span;
   logic                        span_pos;
   logic                        div_start;
   logic                        div_x_busy, div_y_busy, div_x_done, div_y_done;
   logic [ACC_BITS-1:0]         quot_x, quot_y;
   logic [ACC_BITS-1:0]         round_x, round_y;

   // configuration registers
   always_comb begin
      case (csr_index)
         CSR_START_X, CSR_START_Y, CSR_STOP_X, CSR_STOP_Y,
         CSR_BEGIN_FRAME, CSR_END_FRAME: cfg_hit = csr_valid;
         default:                        cfg_hit = 1'b0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         start_x_ff     <= '0;
         start_y_ff     <= '0;
         stop_x_ff      <= '0;
         stop_y_ff      <= '0;
         begin_frame_ff <= '0;
         end_frame_ff   <= '0;
      end else if (csr_valid) begin
         case (csr_index)
            CSR_START_X:     start_x_ff     <= csr_wdata[REG_BITS-1:0];
            CSR_START_Y:     start_y_ff     <= csr_wdata[REG_BITS-1:0];
            CSR_STOP_X:      stop_x_ff      <= csr_wdata[REG_BITS-1:0];
            CSR_STOP_Y:      stop_y_ff      <= csr_wdata[REG_BITS-1:0];
            CSR_BEGIN_FRAME: begin_frame_ff <= csr_wdata[FRAME_BITS-1:0];
            CSR_END_FRAME:   end_frame_ff   <= csr_wdata[FRAME_BITS-1:0];
            default: ;
         endcase
      end
   end

   assign sx       = coord_ext(start_x_ff);
   assign sy       = coord_ext(start_y_ff);
   assign ex       = coord_ext(stop_x_ff);
   assign ey       = coord_ext(stop_y_ff);
   assign diff_x   = $signed({ex[REG_BITS-1], ex}) - $signed({sx[REG_BITS-1], sx});
   assign diff_y   = $signed({ey[REG_BITS-1], ey}) - $signed({sy[REG_BITS-1], sy});
   assign span_pos = end_frame_ff > begin_frame_ff;
   assign span     = end_frame_ff - begin_frame_ff;
   assign div_start = cmd.rearm && span_pos;

   lpa_div u_div_x (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .diff  (diff_x),
      .span  (span),
      .busy  (div_x_busy),
      .done  (div_x_done),
      .quot  (quot_x)
   );

   lpa_div u_div_y (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .diff  (diff_y),
      .span  (span),
      .busy  (div_y_busy),
      .done  (div_y_done),
      .quot  (quot_y)
   );

   assign round_x = accum_x_ff + ROUND_HALF;
   assign round_y = accum_y_ff + ROUND_HALF;

   always_comb begin
      now_in           = now_ff;
      current_frame_in = current_frame_ff;
      elapsed_in       = elapsed_ff;
      accum_x_in       = accum_x_ff;
      accum_y_in       = accum_y_ff;
      step_x_in        = step_x_ff;
      step_y_in        = step_y_ff;
      mcand_x_in       = mcand_x_ff;
      mcand_y_in       = mcand_y_ff;
      pos_x_in         = pos_x_ff;
      pos_y_in         = pos_y_ff;

      if (cmd.load_req) begin
         now_in = req_now_frame;
      end

      if (cmd.rearm) begin
         current_frame_in = begin_frame_ff;
         accum_x_in = {{(ACC_BITS-REG_BITS-FRAC_BITS){sx[REG_BITS-1]}}, sx, {FRAC_BITS{1'b0}}};
         accum_y_in = {{(ACC_BITS-REG_BITS-FRAC_BITS){sy[REG_BITS-1]}}, sy, {FRAC_BITS{1'b0}}};
         step_x_in  = '0;
         step_y_in  = '0;
      end
      if (div_x_done) begin
         step_x_in = quot_x;
      end
      if (div_y_done) begin
         step_y_in = quot_y;
      end

      if (cmd.mul_start) begin
         elapsed_in       = now_ff - current_frame_ff;
         current_frame_in = now_ff;
         mcand_x_in       = step_x_ff;
         mcand_y_in       = step_y_ff;
      end

      // shift-add multiply of elapsed frames by the step, straight into the accumulators
      if (cmd.mul_step) begin
         if (elapsed_ff[0]) begin
            accum_x_in = accum_x_ff + mcand_x_ff;
            accum_y_in = accum_y_ff + mcand_y_ff;
         end
         mcand_x_in = {mcand_x_ff[ACC_BITS-2:0], 1'b0};
         mcand_y_in = {mcand_y_ff[ACC_BITS-2:0], 1'b0};
         elapsed_in = {1'b0, elapsed_ff[FRAME_BITS-1:1]};
      end

      if (cmd.load_stop) begin
         pos_x_in = ex;
         pos_y_in = ey;
      end else if (cmd.load_round) begin
         pos_x_in = round_x[FRAC_BITS+REG_BITS-1:FRAC_BITS];
         pos_y_in = round_y[FRAC_BITS+REG_BITS-1:FRAC_BITS];
      end
   end

   always_ff @(posedge clock) begin
      now_ff           <= now_in;
      current_frame_ff <= current_frame_in;
      elapsed_ff       <= elapsed_in;
      accum_x_ff       <= accum_x_in;
      accum_y_ff       <= accum_y_in;
      step_x_ff        <= step_x_in;
      step_y_ff        <= step_y_in;
      mcand_x_ff       <= mcand_x_in;
      mcand_y_ff       <= mcand_y_in;
      pos_x_ff         <= pos_x_in;
      pos_y_ff         <= pos_y_in;
   end

   always_comb begin
      status.cfg_write    = cfg_hit;
      status.div_busy     = div_x_busy || div_y_busy;
      status.past_end     = now_ff > end_frame_ff;
      status.later        = now_ff > current_frame_ff;
      status.elapsed_zero = elapsed_ff == '0;
   end

   assign rsp_pos_x = pos_x_ff;
   assign rsp_pos_y = pos_y_ff;

endmodule

// File: design/lpa_ctrl.sv
module lpa_ctrl import lpa_pkg::*; (
   input  logic           clock,
   input  logic           reset,
   input  logic           req_valid,
   output logic           req_stall,
   output logic           rsp_valid,
   input  logic           rsp_stall,
   input  lpa_status_type status,
   output lpa_cmd_type    cmd
);

   typedef enum logic [4:0] {
      ST_IDLE = 5'b00001,
      ST_DIV  = 5'b00010,
      ST_EVAL = 5'b00100,
      ST_MUL  = 5'b01000,
      ST_RESP = 5'b10000
   } lpa_state_type;

   lpa_state_type state_ff, state_in;
   logic          rearm_pending_ff, rearm_pending_in;

   always_comb begin
      state_in         = state_ff;
      rearm_pending_in = rearm_pending_ff;
      cmd              = '0;
      req_stall        = 1'b1;
      rsp_valid        = 1'b0;

      case (state_ff)
         ST_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               cmd.load_req = 1'b1;
               if (rearm_pending_ff) begin
                  cmd.rearm        = 1'b1;
                  rearm_pending_in = 1'b0;
                  state_in         = ST_DIV;
               end else begin
                  state_in = ST_EVAL;
               end
            end
         end
         ST_DIV: begin
            if (!status.div_busy) begin
               state_in = ST_EVAL;
            end
         end
         ST_EVAL: begin
            if (status.past_end) begin
               cmd.load_stop = 1'b1;
               state_in      = ST_RESP;
            end else if (status.later) begin
               cmd.mul_start = 1'b1;
               state_in      = ST_MUL;
            end else begin
               cmd.load_round = 1'b1;
               state_in       = ST_RESP;
            end
         end
         ST_MUL: begin
            if (status.elapsed_zero) begin
               cmd.load_round = 1'b1;
               state_in       = ST_RESP;
            end else begin
               cmd.mul_step = 1'b1;
            end
         end
         ST_RESP: begin
            rsp_valid = 1'b1;
            if (!rsp_stall) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      // a write to any of the six registers re-arms the path for the next request
      if (status.cfg_write) begin
         rearm_pending_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff         <= ST_IDLE;
         rearm_pending_ff <= 1'b1;
      end else begin
         state_ff         <= state_in;
         rearm_pending_ff <= rearm_pending_in;
      end
   end

endmodule

// File: verif/tb_fixed_point_line_path_animator.sv
`timescale 1ns / 1ps

module tb_fixed_point_line_path_animator;
   import lpa_pkg::*;

   localparam int QUERY_TARGET = 1600;
   localparam int QUIET_FROM   = 1300;
   localparam logic [FRAME_BITS-1:0] FRAME_MAX = '1;

   class path_scoreboard;
      logic [REG_BITS-1:0]   start_x = '0, start_y = '0, stop_x = '0, stop_y = '0;
      logic [FRAME_BITS-1:0] begin_frame = '0, end_frame = '0;
      bit                    rearm_pending = 1'b1;
      logic [FRAME_BITS-1:0] cur_frame = '0;
      logic [ACC_BITS-1:0]   acc_x = '0, acc_y = '0, step_x = '0, step_y = '0;
      logic [REG_BITS-1:0]   due_x[$], due_y[$];
      int                    errors = 0;

      function void write_reg(logic [CSR_IDX_BITS-1:0] idx, logic [CSR_DATA_BITS-1:0] d);
         case (idx)
            CSR_START_X:     start_x = d[REG_BITS-1:0];
            CSR_START_Y:     start_y = d[REG_BITS-1:0];
            CSR_STOP_X:      stop_x = d[REG_BITS-1:0];
            CSR_STOP_Y:      stop_y = d[REG_BITS-1:0];
            CSR_BEGIN_FRAME: begin_frame = d[FRAME_BITS-1:0];
            CSR_END_FRAME:   end_frame = d[FRAME_BITS-1:0];
            default:         return;
         endcase
         rearm_pending = 1'b1;
      endfunction

      // per-frame step in fixed point, division truncates toward zero
      function logic [ACC_BITS-1:0] frame_step(logic [REG_BITS-1:0] from,
                                               logic [REG_BITS-1:0] to, longint span);
         longint delta;
         delta = (longint'($signed(to)) - longint'($signed(from))) * (longint'(1) <<< FRAC_BITS);
         return ACC_BITS'(delta / span);
      endfunction

      function logic [REG_BITS-1:0] rounded(logic [ACC_BITS-1:0] a);
         logic [ACC_BITS-1:0] t;
         t = a + ROUND_HALF;
         return t[FRAC_BITS +: REG_BITS];
      endfunction

      function void restart_path();
         longint span;
         span = longint'(end_frame) - longint'(begin_frame);
         cur_frame = begin_frame;
         acc_x = ACC_BITS'(longint'($signed(start_x)) <<< FRAC_BITS);
         acc_y = ACC_BITS'(longint'($signed(start_y)) <<< FRAC_BITS);
         if (span > 0) begin
            step_x = frame_step(start_x, stop_x, span);
            step_y = frame_step(start_y, stop_y, span);
         end else begin
            step_x = '0;
            step_y = '0;
         end
         rearm_pending = 1'b0;
      endfunction

      function void note_query(logic [FRAME_BITS-1:0] now);
         logic [FRAME_BITS-1:0] elapsed;
         if (rearm_pending) restart_path();
         if (now > end_frame) begin
            due_x.push_back(stop_x);
            due_y.push_back(stop_y);
         end else begin
            if (now > cur_frame) begin
               elapsed = now - cur_frame;
               cur_frame = now;
               acc_x = acc_x + ACC_BITS'(elapsed) * step_x;
               acc_y = acc_y + ACC_BITS'(elapsed) * step_y;
            end
            due_x.push_back(rounded(acc_x));
            due_y.push_back(rounded(acc_y));
         end
      endfunction

      function void check_pos(logic [REG_BITS-1:0] x, logic [REG_BITS-1:0] y);
         logic [REG_BITS-1:0] ex, ey;
         if (due_x.size() == 0) begin
            $display("%0t: unexpected position x %0d y %0d", $time, $signed(x), $signed(y));
            errors++;
            return;
         end
         ex = due_x.pop_front();
         ey = due_y.pop_front();
         if (x !== ex) begin
            $display("%0t: pos_x expected %0d actual %0d", $time, $signed(ex), $signed(x));
            errors++;
         end
         if (y !== ey) begin
            $display("%0t: pos_y expected %0d actual %0d", $time, $signed(ey), $signed(y));
            errors++;
         end
      endfunction

      function int pending();
         return due_x.size();
      endfunction
   endclass

   logic                      clock;
   logic                      reset;
   logic                      req_valid;
   logic                      req_stall;
   logic [FRAME_BITS-1:0]     req_now_frame;
   logic                      rsp_valid;
   logic                      rsp_stall;
   logic signed [REG_BITS-1:0] rsp_pos_x;
   logic signed [REG_BITS-1:0] rsp_pos_y;
   logic                      csr_valid;
   logic                      csr_ready;
   logic [CSR_IDX_BITS-1:0]   csr_index;
   logic [CSR_DATA_BITS-1:0]  csr_wdata;

   path_scoreboard sb = new();
   bit idle_on = 1'b0;
   bit hold_rsp = 1'b0;
   int sent = 0;

   fixed_point_line_path_animator dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_now_frame(req_now_frame),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_pos_x(rsp_pos_x),
      .rsp_pos_y(rsp_pos_y),
      .csr_valid(csr_valid),
      .csr_ready(csr_ready),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata)
   );

   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (csr_valid && csr_ready) sb.write_reg(csr_index, csr_wdata);
         if (rsp_valid && !rsp_stall) sb.check_pos(rsp_pos_x, rsp_pos_y);
         if (req_valid && !req_stall) sb.note_query(req_now_frame);
      end
   end

   // receiver: random stall bursts, plus one long hold-off on request
   initial begin
      rsp_stall = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_rsp) begin
            rsp_stall = 1'b1;
            repeat (400) @(negedge clock);
            rsp_stall = 1'b0;
            hold_rsp = 1'b0;
         end else if (idle_on && $urandom_range(0, 5) == 0) begin
            rsp_stall = 1'b1;
            repeat ($urandom_range(1, 9)) @(negedge clock);
            rsp_stall = 1'b0;
         end
      end
   end

   initial begin
      #10_000_000;
      $display("tb: failure");
      $finish;
   end

   task automatic send_query(input logic [FRAME_BITS-1:0] f);
      if (idle_on && $urandom_range(0, 4) == 0) begin
         req_valid = 1'b0;
         repeat ($urandom_range(1, 9)) @(negedge clock);
      end
      req_valid = 1'b1;
      req_now_frame = f;
      do @(posedge clock); while (req_stall);
      @(negedge clock);
      sent++;
   endtask

   task automatic drain();
      req_valid = 1'b0;
      while (sb.pending() != 0) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic write_csr(input logic [CSR_IDX_BITS-1:0] idx,
                            input logic [CSR_DATA_BITS-1:0] d);
      csr_valid = 1'b1;
      csr_index = idx;
      csr_wdata = d;
      do @(posedge clock); while (!csr_ready);
      @(negedge clock);
      csr_valid = 1'b0;
   endtask

   // unused upper bits of the write data carry noise
   task automatic set_path(input logic [REG_BITS-1:0] sx, input logic [REG_BITS-1:0] sy,
                           input logic [REG_BITS-1:0] tx, input logic [REG_BITS-1:0] ty,
                           input logic [FRAME_BITS-1:0] b, input logic [FRAME_BITS-1:0] e);
      drain();
      write_csr(CSR_START_X, {16'($urandom), sx});
      write_csr(CSR_START_Y, {16'($urandom), sy});
      write_csr(CSR_STOP_X, {16'($urandom), tx});
      write_csr(CSR_STOP_Y, {16'($urandom), ty});
      write_csr(CSR_BEGIN_FRAME, {1'($urandom), b});
      write_csr(CSR_END_FRAME, {1'($urandom), e});
   endtask

   function automatic logic [REG_BITS-1:0] pick_coord();
      case ($urandom_range(0, 7))
         0: return 16'h8000;
         1: return 16'h7FFF;
         2: return 16'h0000;
         3: return 16'hFFFF;
         4, 5: return REG_BITS'($signed($urandom_range(0, 400)) - 200);
         default: return REG_BITS'($urandom);
      endcase
   endfunction

   initial begin
      int                    phase_no;
      int                    phase_len;
      logic [FRAME_BITS-1:0] b, e, f;
      logic [31:0]           stride, inc;

      reset = 1'b1;
      req_valid = 1'b0;
      req_now_frame = '0;
      csr_valid = 1'b0;
      csr_index = '0;
      csr_wdata = '0;
      repeat (9) @(negedge clock);
      reset = 1'b0;

      // all registers still at reset: a zero-length path at the origin
      send_query(31'd0);
      send_query(31'd5);

      set_path(16'h8000, 16'h7FFF, 16'h7FFF, 16'h8000, 31'd10, 31'd20);
      send_query(31'd5);
      send_query(31'd10);
      send_query(31'd11);
      send_query(31'd15);
      send_query(31'd15);
      send_query(31'd12);
      send_query(31'd20);
      send_query(31'd21);
      send_query(FRAME_MAX);

      // out-of-range indexes must not restart the path
      drain();
      write_csr(CSR_IDX_BITS'(6), 32'hFFFF_FFFF);
      write_csr(CSR_IDX_BITS'(7), 32'h1234_5678);
      send_query(31'd20);

      // end before begin, and an empty span
      set_path(16'd100, 16'd200, 16'hFF00, 16'd7, 31'd100, 31'd50);
      send_query(31'd60);
      send_query(31'd40);
      set_path(16'd3, 16'hFFFD, 16'd9, 16'd1, 31'd7, 31'd7);
      send_query(31'd7);
      send_query(31'd8);

      // rounding ties go up
      set_path(16'd0, 16'd0, 16'd1, 16'hFFFF, 31'd0, 31'd2);
      send_query(31'd1);

      // longest span, huge elapsed counts
      set_path(16'd0, 16'h8000, 16'd1, 16'h7FFF, 31'd0, FRAME_MAX);
      send_query(31'h4000_0000);
      send_query(FRAME_MAX);

      phase_no = 0;
      while (sent < QUERY_TARGET) begin
         drain();
         phase_no++;
         idle_on = (sent < QUIET_FROM) && ($urandom_range(0, 3) != 0);

         b = 31'($urandom_range(0, 2000));
         case ($urandom_range(0, 9))
            0: e = b;
            1: e = (b > 20) ? b - 31'($urandom_range(1, 20)) : '0;
            2, 3, 4, 5: e = b + 31'($urandom_range(1, 60));
            6, 7: e = b + 31'($urandom_range(61, 5000));
            8: begin
               b = 31'($urandom_range(0, 100));
               e = FRAME_MAX;
            end
            default: begin
               b = FRAME_MAX - 31'($urandom_range(0, 5000));
               e = b + 31'($urandom_range(0, 32'(FRAME_MAX - b)));
            end
         endcase
         if ($urandom_range(0, 3) != 0 || phase_no == 1) begin
            set_path(pick_coord(), pick_coord(), pick_coord(), pick_coord(), b, e);
         end else begin
            if ($urandom_range(0, 1)) write_csr(CSR_START_X, {16'($urandom), pick_coord()});
            if ($urandom_range(0, 1)) write_csr(CSR_STOP_Y, {16'($urandom), pick_coord()});
            if ($urandom_range(0, 1)) write_csr(CSR_END_FRAME, {1'($urandom), e});
            if ($urandom_range(0, 3) == 0) write_csr(CSR_IDX_BITS'($urandom_range(6, 7)), $urandom);
         end

         if (phase_no == 3) hold_rsp = 1'b1;
         phase_len = (phase_no == 3) ? 50 : $urandom_range(15, 50);
         stride = (sb.end_frame > sb.begin_frame) ?
                  32'((sb.end_frame - sb.begin_frame) / 16) + 1 : 4;
         f = (sb.begin_frame > 3) ? sb.begin_frame - 3 : '0;

         for (int i = 0; i < phase_len; i++) begin
            if (phase_no == 6 && i == phase_len / 2) drain();
            case ($urandom_range(0, 19))
               0: send_query(31'($urandom));
               1: begin
                  inc = $urandom_range(0, stride);
                  f = (32'(f) > inc) ? f - 31'(inc) : '0;
                  send_query(f);
               end
               default: begin
                  inc = $urandom_range(0, stride);
                  f = (32'(FRAME_MAX - f) < inc) ? FRAME_MAX : f + 31'(inc);
                  send_query(f);
               end
            endcase
         end
      end

      drain();
      repeat (80) @(posedge clock);
      if (sb.errors == 0 && sb.pending() == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule

// File: filelist.f
design/lpa_pkg.sv
design/lpa_div.sv
design/lpa_datapath.sv
design/lpa_ctrl.sv
design/fixed_point_line_path_animator.sv
verif/tb_fixed_point_line_path_animator.sv
